### hw/rtl/tab_pkg.sv
// tab_pkg: shared types and constants for the tick alarm break timer
// used by tab_step and tick_alarm_break_timer; depends on nothing else
`timescale 1ns / 1ps

package tab_pkg;

  // field widths
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned MS_W    = 22;
  localparam int unsigned TICK_W  = 32;
  localparam int unsigned CNT9_W  = 9;
  localparam int unsigned CFG_W   = 8;

  // item kinds carried in s_tuser
  localparam logic [MODE_W-1:0] MODE_TICK      = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SET_ALARM = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RESTART   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNUSED    = 2'd3;

  // configuration register indexes
  localparam logic CFG_LED_HALF_PERIOD = 1'b0;
  localparam logic CFG_BREAK_HOLDOFF   = 1'b1;

  // largest value of a 22-bit ms field
  localparam logic [MS_W-1:0] MS_MAX = {MS_W{1'b1}};

  // timer state carried from item to item
  typedef struct packed {
    logic [TICK_W-1:0]  tick_counter;
    logic [CNT9_W-1:0]  led_counter;
    logic               led_level;
    logic               alarm_armed;
    logic [MS_W-1:0]    alarm_remaining;
    logic [CNT9_W-1:0]  holdoff_counter;
  } tab_state_t;

  // one result item
  typedef struct packed {
    logic [MS_W-1:0]    time_left_ms;
    logic               break_clear;
    logic               break_detected;
    logic               alarm_fired;
    logic               watchdog_kick;
    logic               led_on;
    logic [TICK_W-1:0]  tick_value;
  } tab_result_t;

endpackage

### hw/rtl/tab_step.sv
// tab_step: combinational update of the timer state for one item
// depends on tab_pkg for the state and result structs and the mode codes
`timescale 1ns / 1ps

module tab_step #(
  parameter int unsigned TICK_MS = 4
) (
  input  tab_pkg::tab_state_t             cur,
  input  logic [tab_pkg::MODE_W-1:0]      mode,
  input  logic [tab_pkg::MS_W-1:0]        alarm_ms,
  input  logic                            break_seen,
  input  logic [tab_pkg::CFG_W-1:0]       led_half_period,
  input  logic [tab_pkg::CFG_W-1:0]       break_holdoff,
  output tab_pkg::tab_state_t             nxt,
  output tab_pkg::tab_result_t            res
);

  // ceil(ms / TICK_MS) by reciprocal multiply, exact for a 23-bit dividend
  localparam int unsigned DIV_SHIFT = 28;
  localparam int unsigned DIVD_W    = tab_pkg::MS_W + 1;
  localparam int unsigned RECIP_W   = DIV_SHIFT + 1;
  localparam int unsigned PROD_W    = DIVD_W + RECIP_W;
  localparam logic [RECIP_W-1:0] DIV_RECIP =
    RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS));
  localparam int unsigned TMS_W = $clog2(TICK_MS + 1);
  localparam logic [TMS_W-1:0] TICK_MS_V = TMS_W'(TICK_MS);
  localparam int unsigned LEFT_W = tab_pkg::MS_W + TMS_W;

  logic [DIVD_W-1:0]             dividend;
  logic [PROD_W-1:0]             div_prod;
  logic [DIVD_W-1:0]             quotient;
  logic [LEFT_W-1:0]             left_prod;
  logic [tab_pkg::CNT9_W-1:0]    led_inc;
  logic [tab_pkg::CNT9_W-1:0]    hold_pre;
  logic [tab_pkg::CNT9_W-1:0]    hold_inc;
  logic [tab_pkg::MS_W-1:0]      rem_dec;
  tab_pkg::tab_state_t           tk;
  logic                          fired;
  logic                          detected;
  logic                          clear;

  // alarm tick count and time left
  assign dividend  = DIVD_W'(alarm_ms) + DIVD_W'(TICK_MS - 1);
  assign div_prod  = PROD_W'(dividend) * PROD_W'(DIV_RECIP);
  assign quotient  = div_prod[DIV_SHIFT +: DIVD_W];
  assign left_prod = LEFT_W'(cur.alarm_remaining) * LEFT_W'(TICK_MS_V);

  // one housekeeping tick; set alarm enters it with the holdoff cleared
  always_comb begin
    tk       = cur;
    fired    = 1'b0;
    detected = 1'b0;
    clear    = 1'b0;
    hold_pre = (mode == tab_pkg::MODE_SET_ALARM) ? '0 : cur.holdoff_counter;

    tk.tick_counter = cur.tick_counter + 1'b1;

    // run led
    led_inc = cur.led_counter + 1'b1;
    if (led_inc > {1'b0, led_half_period}) begin
      tk.led_level   = ~cur.led_level;
      tk.led_counter = '0;
    end else begin
      tk.led_counter = led_inc;
    end

    // alarm countdown
    rem_dec = cur.alarm_remaining - 1'b1;
    if (cur.alarm_armed) begin
      tk.alarm_remaining = rem_dec;
      if (rem_dec == '0) begin
        tk.alarm_armed = 1'b0;
        fired          = 1'b1;
      end
    end

    // break holdoff and break sampling
    hold_inc = hold_pre + 1'b1;
    tk.holdoff_counter = hold_pre;
    if (hold_pre != '0) begin
      if (hold_inc > {1'b0, break_holdoff}) begin
        clear              = 1'b1;
        tk.holdoff_counter = '0;
      end else begin
        tk.holdoff_counter = hold_inc;
      end
    end else if (break_seen) begin
      clear              = 1'b1;
      detected           = 1'b1;
      tk.holdoff_counter = 9'd1;
    end
  end

  // select by item kind
  always_comb begin
    nxt = cur;
    res = '0;
    unique case (mode)
      tab_pkg::MODE_TICK: begin
        nxt                = tk;
        res.watchdog_kick  = 1'b1;
        res.alarm_fired    = fired;
        res.break_detected = detected;
        res.break_clear    = clear;
      end
      tab_pkg::MODE_SET_ALARM: begin
        nxt                 = tk;
        nxt.alarm_remaining = quotient[tab_pkg::MS_W-1:0];
        nxt.alarm_armed     = (quotient[tab_pkg::MS_W-1:0] != '0);
        nxt.tick_counter    = '0;
        nxt.holdoff_counter = 9'd1;
        res.watchdog_kick   = 1'b1;
        res.alarm_fired     = fired;
        res.break_detected  = detected;
        res.break_clear     = clear;
        res.time_left_ms    = (left_prod > LEFT_W'(tab_pkg::MS_MAX)) ?
                              tab_pkg::MS_MAX : left_prod[tab_pkg::MS_W-1:0];
      end
      tab_pkg::MODE_RESTART: begin
        nxt.tick_counter    = '0;
        nxt.holdoff_counter = 9'd1;
        res.watchdog_kick   = 1'b1;
      end
      tab_pkg::MODE_UNUSED: begin
        nxt = cur;
      end
      default: begin
        nxt = cur;
      end
    endcase
    res.tick_value = nxt.tick_counter;
    res.led_on     = nxt.led_level;
  end

endmodule

### hw/rtl/tick_alarm_break_timer.sv
// tick_alarm_break_timer: top level with input register, state, config and result register
// depends on tab_pkg and tab_step
`timescale 1ns / 1ps

// Periodic tick timer with run LED, alarm countdown and console break
// detection. Each transaction on the s_ side is one item (tick, set alarm or
// restart) and produces exactly one result transaction on the m_ side. The
// block takes one item per clock cycle when the result side keeps up: an
// item is held in the input register, tab_step computes its state update
// and result combinationally, and the result is loaded into the output
// register when that register is free or being taken (m_tvalid low or
// m_tready high). The state loop closes through a single state register.
// Registers are written on the cfg_ port (always ready) and should only
// change while no item is in flight.

module tick_alarm_break_timer #(
  parameter int unsigned TICK_MS = 4
) (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // alarm_ms[21:0], break_seen[22], zero[23]
  input  logic [1:0]  s_tuser,   // mode[1:0]
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // tick_value[31:0], led_on[32], watchdog_kick[33],
                                 // alarm_fired[34], break_detected[35],
                                 // break_clear[36], time_left_ms[58:37], zero[63:59]
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int unsigned LED_RESET_I  = ((500 / TICK_MS) > 255) ? 255 : (500 / TICK_MS);
  localparam int unsigned HOLD_RESET_I = ((1000 / TICK_MS) > 255) ? 255 : (1000 / TICK_MS);
  localparam logic [tab_pkg::CFG_W-1:0] LED_RESET  = tab_pkg::CFG_W'(LED_RESET_I);
  localparam logic [tab_pkg::CFG_W-1:0] HOLD_RESET = tab_pkg::CFG_W'(HOLD_RESET_I);

  logic                          in_valid;
  logic [tab_pkg::MODE_W-1:0]    in_mode;
  logic [tab_pkg::MS_W-1:0]      in_ms;
  logic                          in_brk;
  logic                          advance;
  logic [tab_pkg::CFG_W-1:0]     led_half_period;
  logic [tab_pkg::CFG_W-1:0]     break_holdoff;
  tab_pkg::tab_state_t           state;
  tab_pkg::tab_state_t           state_next;
  tab_pkg::tab_result_t          result;

  // handshake
  assign advance   = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_mode <= s_tuser;
      in_ms   <= s_tdata[21:0];
      in_brk  <= s_tdata[22];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      led_half_period <= LED_RESET;
      break_holdoff   <= HOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tab_pkg::CFG_LED_HALF_PERIOD: led_half_period <= cfg_data;
        tab_pkg::CFG_BREAK_HOLDOFF:   break_holdoff   <= cfg_data;
        default:                      led_half_period <= led_half_period;
      endcase
    end
  end

  // per-item update
  tab_step #(
    .TICK_MS (TICK_MS)
  ) u_step (
    .cur             (state),
    .mode            (in_mode),
    .alarm_ms        (in_ms),
    .break_seen      (in_brk),
    .led_half_period (led_half_period),
    .break_holdoff   (break_holdoff),
    .nxt             (state_next),
    .res             (result)
  );

  // timer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.tick_counter    <= '0;
      state.led_counter     <= '0;
      state.led_level       <= 1'b0;
      state.alarm_armed     <= 1'b0;
      state.alarm_remaining <= '0;
      state.holdoff_counter <= 9'd1;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {5'd0, result};
    end
  end

endmodule
